/* rtl/topa_pkg.sv */
`default_nettype none

package topa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int SELECT_W    = 2;
    localparam int INDEX_W     = 8;
    localparam int VEC_COUNT_W = 3;
    localparam int LENGTH_W    = 9;
    localparam int NUM_LENGTHS = 4;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_ACCUM = 1'b1
    } t_command;

    typedef logic [REG_IDX_W-1:0] t_reg_index;

    localparam t_reg_index REG_VECTOR_COUNT = 3'd0;
    localparam t_reg_index REG_LENGTH_DIM0  = 3'd1;
    localparam t_reg_index REG_LENGTH_DIM1  = 3'd2;
    localparam t_reg_index REG_LENGTH_DIM2  = 3'd3;
    localparam t_reg_index REG_LENGTH_DIM3  = 3'd4;

endpackage

`default_nettype wire

/* rtl/topa_if.sv */
`default_nettype none

interface topa_in_if import topa_pkg::*; ();
    logic                valid;
    logic                ready;
    t_command            command;
    logic [SELECT_W-1:0] vector_select;
    logic [INDEX_W-1:0]  element_index;
    t_value              data_value;

    modport source (output valid, command, vector_select, element_index, data_value,
                    input ready);
    modport sink   (input valid, command, vector_select, element_index, data_value,
                    output ready);
endinterface

interface topa_out_if import topa_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value sum_value;
    logic   last_element;

    modport source (output valid, sum_value, last_element, input ready);
    modport sink   (input valid, sum_value, last_element, output ready);
endinterface

`default_nettype wire

/* rtl/topa_ram.sv */
`default_nettype none

module topa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tensor_outer_product_accumulate.sv */
// Outer-product accumulate over a tensor of rank one to MAX_VECTORS.
// Input channel i_in: a load item (command CMD_LOAD) writes one vector element
// into the vector store and restarts the position counter; it gives no result.
// An accumulate item (CMD_ACCUM) carries one tensor element, row-major, last
// dimension fastest, and gives one result item on o_out: the element plus the
// product of the selected element of each vector, wrapping at 32 bits, with
// last_element set on the final element of the tensor.
// The APB port sets the rank and the four vector lengths; the user must write
// it only while the block is idle; the block itself does not enforce this, and
// any register write restarts the position. One shared multiplier walks the
// vectors, one store read and one multiply per dimension in the run state,
// then a drain state and a sum state. The sum goes into the output register,
// and the next item is taken while it waits. If the receiver stalls with a
// result still in the output register, the block holds the next sum until
// the register frees.
// Reset clears the position, the sequencer and the output register, and sets
// all registers to one. The vector store holds no defined data until loaded.
`default_nettype none

module tensor_outer_product_accumulate
    import topa_pkg::*;
#(
    parameter int MAX_VECTORS = 4,
    parameter int MAX_LENGTH  = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    topa_in_if.sink                    i_in,
    topa_out_if.source                 o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DIM_W  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int RK_W   = $clog2(MAX_VECTORS + 1);
    localparam int DIG_W  = $clog2(MAX_LENGTH);
    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
    localparam int DEPTH  = MAX_VECTORS * MAX_LENGTH;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_SUM
    } t_state;

    function automatic logic [LEN_W-1:0] len_clamp(input logic [LENGTH_W-1:0] v);
        logic [LEN_W-1:0] res;
        if (v == '0) begin
            res = LEN_W'(1);
        end else if (32'(v) > 32'(MAX_LENGTH)) begin
            res = LEN_W'(MAX_LENGTH);
        end else begin
            res = LEN_W'(v);
        end
        return res;
    endfunction

    t_state                               r_state;
    logic [VEC_COUNT_W-1:0]               r_vector_count;
    logic [LENGTH_W-1:0]                  r_length [NUM_LENGTHS];
    logic [MAX_VECTORS-1:0][DIG_W-1:0]    r_digit;
    logic [MAX_VECTORS-1:0][DIG_W-1:0]    n_digit;
    logic [DIM_W-1:0]                     r_dim;
    logic                                 r_rd_pend;
    logic [VALUE_WIDTH-1:0]               r_prod;
    t_value                               r_data;
    logic                                 r_out_valid;
    t_value                               r_sum;
    logic                                 r_last;

    logic [LEN_W-1:0]       w_len_eff [MAX_VECTORS];
    logic [RK_W-1:0]        w_rank;
    logic [DIM_W-1:0]       w_last_dim;
    logic [DIG_W-1:0]       w_comp;
    logic                   w_carry;
    logic                   w_in_acc;
    logic                   w_out_load;
    logic                   w_cfg_wr;
    t_reg_index             w_cfg_idx;
    logic                   w_wr_en;
    logic [ADDR_W-1:0]      w_wr_addr;
    logic                   w_rd_en;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic [VALUE_WIDTH-1:0] w_rd_data;

    // Effective vector lengths; dimensions without a register have length one.
    for (genvar g = 0; g < MAX_VECTORS; g++) begin : g_len
        if (g < NUM_LENGTHS) begin : g_reg
            assign w_len_eff[g] = len_clamp(r_length[g]);
        end else begin : g_one
            assign w_len_eff[g] = LEN_W'(1);
        end
    end

    always_comb begin
        if (r_vector_count == '0) begin
            w_rank = RK_W'(1);
        end else if (32'(r_vector_count) > 32'(MAX_VECTORS)) begin
            w_rank = RK_W'(MAX_VECTORS);
        end else begin
            w_rank = RK_W'(r_vector_count);
        end
    end

    assign w_last_dim = DIM_W'(w_rank - RK_W'(1));

    assign w_comp = (LEN_W'(r_digit[r_dim]) >= w_len_eff[r_dim])
                  ? DIG_W'(w_len_eff[r_dim] - LEN_W'(1)) : r_digit[r_dim];

    // Position advance, last dimension fastest.
    always_comb begin
        n_digit = r_digit;
        w_carry = 1'b1;
        for (int d = MAX_VECTORS - 1; d >= 0; d--) begin
            if (d < int'(w_rank) && w_carry) begin
                if ((LEN_W'(r_digit[d]) + LEN_W'(1)) >= w_len_eff[d]) begin
                    n_digit[d] = '0;
                end else begin
                    n_digit[d] = r_digit[d] + DIG_W'(1);
                    w_carry    = 1'b0;
                end
            end
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == S_SUM) && (!r_out_valid || o_out.ready);

    assign o_out.valid        = r_out_valid;
    assign o_out.sum_value    = r_sum;
    assign o_out.last_element = r_last;

    assign w_wr_en = w_in_acc && (i_in.command == CMD_LOAD)
                  && (32'(i_in.vector_select) < 32'(MAX_VECTORS))
                  && (32'(i_in.element_index) < 32'(MAX_LENGTH));
    assign w_wr_addr = ADDR_W'(i_in.vector_select) * ADDR_W'(MAX_LENGTH)
                     + ADDR_W'(i_in.element_index);
    assign w_rd_en   = (r_state == S_RUN);
    assign w_rd_addr = ADDR_W'(r_dim) * ADDR_W'(MAX_LENGTH) + ADDR_W'(w_comp);

    topa_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_in.data_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[APB_ADDR_W-1:2];

    always_comb begin
        case (w_cfg_idx)
            REG_VECTOR_COUNT: prdata = APB_DATA_W'(r_vector_count);
            REG_LENGTH_DIM0:  prdata = APB_DATA_W'(r_length[0]);
            REG_LENGTH_DIM1:  prdata = APB_DATA_W'(r_length[1]);
            REG_LENGTH_DIM2:  prdata = APB_DATA_W'(r_length[2]);
            REG_LENGTH_DIM3:  prdata = APB_DATA_W'(r_length[3]);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vector_count <= VEC_COUNT_W'(1);
            for (int i = 0; i < NUM_LENGTHS; i++) begin
                r_length[i] <= LENGTH_W'(1);
            end
            r_digit     <= '0;
            r_dim       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= w_rd_en;
            if (r_rd_pend) begin
                r_prod <= r_prod * w_rd_data;
            end

            if (o_out.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in.command == CMD_LOAD) begin
                            r_digit <= '0;
                        end else begin
                            r_data  <= i_in.data_value;
                            r_prod  <= VALUE_WIDTH'(1);
                            r_dim   <= '0;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (r_dim == w_last_dim) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_dim <= r_dim + DIM_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (w_out_load) begin
                        r_sum       <= t_value'(r_data + r_prod);
                        r_last      <= w_carry;
                        r_out_valid <= 1'b1;
                        r_digit     <= n_digit;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_cfg_wr) begin
                case (w_cfg_idx)
                    REG_VECTOR_COUNT: begin
                        r_vector_count <= pwdata[VEC_COUNT_W-1:0];
                        r_digit        <= '0;
                    end
                    REG_LENGTH_DIM0: begin
                        r_length[0] <= pwdata[LENGTH_W-1:0];
                        r_digit     <= '0;
                    end
                    REG_LENGTH_DIM1: begin
                        r_length[1] <= pwdata[LENGTH_W-1:0];
                        r_digit     <= '0;
                    end
                    REG_LENGTH_DIM2: begin
                        r_length[2] <= pwdata[LENGTH_W-1:0];
                        r_digit     <= '0;
                    end
                    REG_LENGTH_DIM3: begin
                        r_length[3] <= pwdata[LENGTH_W-1:0];
                        r_digit     <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_no_rd_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && w_rd_en))
        else $error("vector store read and write in the same cycle");

    a_load_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.command == CMD_LOAD) |=> (r_digit == '0))
        else $error("load item did not clear the position");

    a_last_wraps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_carry && !w_cfg_wr) |=> (r_digit == '0))
        else $error("position not zero after the last tensor element");

    a_sum_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && r_out_valid && !o_out.ready) |=> (r_state == S_SUM))
        else $error("sum overwrote a result still waiting in the output register");

    a_drain_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> $past(r_state == S_RUN))
        else $error("drain cycle not preceded by a store read");
`endif

endmodule

`default_nettype wire
